// File: sv/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is held
`define CHK_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication check, muted while reset is held
`define CHK_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// File: sv/itar_pkg.sv
// ----------------------------------------------------------------------------
// itar_pkg
// Types, constants and helpers for the integer to radix ascii converter.
// ----------------------------------------------------------------------------
package itar_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int RADIX_BITS   = 6;
  localparam int CHAR_BITS    = 7;
  localparam int DIGIT_BITS   = 5;
  localparam int MAX_DIGITS   = VALUE_BITS;
  localparam int DIG_IDX_BITS = $clog2(MAX_DIGITS);
  localparam int DIG_CNT_BITS = $clog2(MAX_DIGITS + 1);
  localparam int BIT_CNT_BITS = $clog2(VALUE_BITS);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RADIX_BITS-1:0]   RADIX_MIN  = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0]   RADIX_MAX  = RADIX_BITS'(32);
  localparam logic [RADIX_BITS-1:0]   RADIX_DEC  = RADIX_BITS'(10);
  localparam logic [CHAR_BITS-1:0]    CHAR_ZERO  = CHAR_BITS'(48);
  localparam logic [CHAR_BITS-1:0]    CHAR_ALPHA = CHAR_BITS'(65);
  localparam logic [CHAR_BITS-1:0]    CHAR_DASH  = CHAR_BITS'(45);
  localparam logic [CHAR_BITS-1:0]    CHAR_NONE  = '0;
  localparam logic [DIGIT_BITS-1:0]   DIGIT_TEN  = DIGIT_BITS'(10);
  localparam logic [BIT_CNT_BITS-1:0] BIT_LAST   = BIT_CNT_BITS'(VALUE_BITS - 1);

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0]        radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last;
    logic                 bad_radix;
  } out_item_t;

  // classified conversion waiting in the queue
  typedef struct packed {
    logic [VALUE_BITS-1:0] mag;
    logic [RADIX_BITS-1:0] radix;
    logic                  dash;
    logic                  bad;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [CHAR_BITS-1:0] digit_ascii(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] ch;
    if (d >= DIGIT_TEN) begin
      ch = CHAR_ALPHA + CHAR_BITS'(d - DIGIT_TEN);
    end else begin
      ch = CHAR_ZERO + CHAR_BITS'(d);
    end
    return ch;
  endfunction

endpackage

// File: sv/itar_front.sv
// ----------------------------------------------------------------------------
// itar_front
// Accepts input items, checks the radix, takes the magnitude and queues a job.
// ----------------------------------------------------------------------------
module itar_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  itar_pkg::in_item_t in_item,
  input  itar_pkg::q_stat_t  q_stat,
  output logic               push,
  output itar_pkg::job_t     job
);
  import itar_pkg::*;

  logic                  neg;
  logic [VALUE_BITS-1:0] raw;

  assign raw      = in_item.value;
  assign neg      = raw[VALUE_BITS-1];
  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    // most negative value wraps to 2^(n-1) as an unsigned magnitude
    job.mag   = neg ? (~raw + VALUE_BITS'(1)) : raw;
    job.radix = in_item.radix;
    job.dash  = neg && (in_item.radix == RADIX_DEC);
    job.bad   = (in_item.radix < RADIX_MIN) || (in_item.radix > RADIX_MAX);
  end

endmodule

// File: sv/itar_fifo.sv
// ----------------------------------------------------------------------------
// itar_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itar_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  itar_pkg::job_t    push_job,
  input  logic              pop,
  output itar_pkg::job_t    pop_job,
  output itar_pkg::q_stat_t q_stat
);
  import itar_pkg::*;

  job_t                 slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] cnt_r;

  assign q_stat.full  = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_job      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_BITS'(push) - QCNT_BITS'(pop);
    end
  end

  `CHK_IMPL(a_no_pop_empty, pop, !q_stat.empty, "itar_fifo: pop from empty queue")
  `CHK_IMPL(a_no_push_full, push, !q_stat.full, "itar_fifo: push into full queue")

endmodule

// File: sv/itar_back.sv
// ----------------------------------------------------------------------------
// itar_back
// Divides the magnitude by the radix one bit a cycle, stacks the digits and
// sends them out most significant first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itar_back (
  input  logic                clk,
  input  logic                rst_n,
  input  itar_pkg::q_stat_t   q_stat,
  input  itar_pkg::job_t      pop_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output itar_pkg::out_item_t out_item
);
  import itar_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_SIGN, S_EMIT, S_ERR} state_t;

  state_t                  state_r;
  logic [VALUE_BITS-1:0]   quo_r;
  logic [DIGIT_BITS-1:0]   rem_r;
  logic [RADIX_BITS-1:0]   radix_r;
  logic                    dash_r;
  logic [BIT_CNT_BITS-1:0] bit_cnt_r;
  logic [DIG_CNT_BITS-1:0] wr_cnt_r;
  logic [DIG_IDX_BITS-1:0] rd_idx_r;
  logic [DIGIT_BITS-1:0]   digit_mem [MAX_DIGITS];
  logic                    out_valid_r;
  out_item_t               out_item_r;

  logic [RADIX_BITS-1:0]   trial;
  logic                    ge;
  logic [RADIX_BITS-1:0]   rem_nxt;
  logic [VALUE_BITS-1:0]   quo_nxt;
  logic                    digit_done;
  logic                    out_free;
  logic                    emit;

  assign trial      = {rem_r, quo_r[VALUE_BITS-1]};
  assign ge         = (trial >= radix_r);
  assign rem_nxt    = ge ? (trial - radix_r) : trial;
  assign quo_nxt    = {quo_r[VALUE_BITS-2:0], ge};
  assign digit_done = (state_r == S_DIV) && (bit_cnt_r == BIT_LAST);
  assign out_free   = !out_valid_r || out_ready;
  // output register loads a new item this cycle
  assign emit       = out_free &&
                      ((state_r == S_SIGN) || (state_r == S_EMIT) || (state_r == S_ERR));
  assign pop        = (state_r == S_IDLE) && !q_stat.empty;
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;

  // digit stack, least significant digit at the bottom
  always_ff @(posedge clk) begin
    if (digit_done) begin
      digit_mem[wr_cnt_r[DIG_IDX_BITS-1:0]] <= rem_nxt[DIGIT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            quo_r     <= pop_job.mag;
            rem_r     <= '0;
            radix_r   <= pop_job.radix;
            dash_r    <= pop_job.dash;
            bit_cnt_r <= '0;
            wr_cnt_r  <= '0;
            state_r   <= pop_job.bad ? S_ERR : S_DIV;
          end
        end
        S_DIV: begin
          quo_r     <= quo_nxt;
          rem_r     <= digit_done ? '0 : rem_nxt[DIGIT_BITS-1:0];
          bit_cnt_r <= bit_cnt_r + 1'b1;
          if (digit_done) begin
            wr_cnt_r <= wr_cnt_r + 1'b1;
            rd_idx_r <= wr_cnt_r[DIG_IDX_BITS-1:0];
            if (quo_nxt == '0) begin
              state_r <= dash_r ? S_SIGN : S_EMIT;
            end
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_item_r.digit_char <= CHAR_DASH;
            out_item_r.last       <= 1'b0;
            out_item_r.bad_radix  <= 1'b0;
            state_r               <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_item_r.digit_char <= digit_ascii(digit_mem[rd_idx_r]);
            out_item_r.last       <= (rd_idx_r == '0);
            out_item_r.bad_radix  <= 1'b0;
            rd_idx_r              <= rd_idx_r - 1'b1;
            if (rd_idx_r == '0) begin
              state_r <= S_IDLE;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_item_r.digit_char <= CHAR_NONE;
            out_item_r.last       <= 1'b1;
            out_item_r.bad_radix  <= 1'b1;
            state_r               <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `CHK_IMPL(a_rem_below_radix, state_r == S_DIV, RADIX_BITS'(rem_r) < radix_r,
            "itar_back: partial remainder not below radix")
  `CHK_IMPL(a_stack_bound, state_r == S_DIV, wr_cnt_r < DIG_CNT_BITS'(MAX_DIGITS),
            "itar_back: digit stack overflow")
  `CHK_IMPL(a_err_is_last, out_valid_r && out_item_r.bad_radix,
            out_item_r.last && (out_item_r.digit_char == CHAR_NONE),
            "itar_back: error item must be a lone last item")

endmodule

// File: sv/int_to_radix_ascii_top.sv
// ----------------------------------------------------------------------------
// int_to_radix_ascii_top
// Converts a signed integer to ascii digits in a radix from 2 to 32.
// ----------------------------------------------------------------------------
// usage:
//   in channel  : in_valid/in_ready with in_item (value, radix); one item is
//                 one conversion
//   out channel : out_valid/out_ready with out_item, one character per item,
//                 most significant digit first, last set on the final one;
//                 a leading '-' only for negative values in base 10
//   bad radix   : one out item with digit_char 0, last and bad_radix set
// flow:
//   the bit-serial divider makes a full pass over all 32 magnitude bits for
//   each digit, up to 32 digits for a base 2 result; a two-entry job queue
//   lets the input side take new items while the divider works; in_ready
//   drops only when the queue is full
// reset: rst_n low empties the queue and drops out_valid
// stall: out_ready held low freezes emission; the output register holds its
//   item and the divider waits, nothing is lost
// ----------------------------------------------------------------------------
module int_to_radix_ascii_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  itar_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output itar_pkg::out_item_t out_item
);
  import itar_pkg::*;

  q_stat_t q_stat;
  job_t    push_job;
  job_t    pop_job;
  logic    push;
  logic    pop;

  itar_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .push     (push),
    .job      (push_job)
  );

  itar_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  itar_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
